// ----- rtl/score_event_sequencer_unit_assert.svh -----
// Assertion macros for the score event sequencer checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef SCORE_EVENT_SEQUENCER_UNIT_ASSERT_SVH
`define SCORE_EVENT_SEQUENCER_UNIT_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define SESU_ASSERT_IMPLY(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("sequencer check failed: same-cycle implication");

// Condition a implies condition b in the next cycle.
`define SESU_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("sequencer check failed: next-cycle implication");

`endif

// ----- rtl/sesu_pkg.sv -----
// Shared types and constants of the score event sequencer.
// No dependencies; imported by every module of the block but sesu_ram.
`default_nettype none

package sesu_pkg;

   // Score memory geometry
   localparam int SCORE_DEPTH = 4096;
   localparam int PTR_W       = $clog2(SCORE_DEPTH);

   // Beat field widths
   localparam int OP_W        = 3;
   localparam int ADDR_W      = 12;
   localparam int DATA_W      = 8;
   localparam int KIND_W      = 2;
   localparam int NOTE_W      = 8;
   localparam int REQ_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;

   // Score decoding
   localparam logic [DATA_W-1:0] STOP_BYTE = 8'hFF;
   localparam int NOTE_END_BIT = 7;
   localparam int MAX_CHORD    = 63;
   localparam int CHORD_W      = $clog2(MAX_CHORD);
   localparam int TIME_SHIFT   = 8;

   // Decay envelope counter
   localparam logic [7:0] DECAY_MAX  = 8'd200;
   localparam logic [7:0] DECAY_FIRE = 8'd150;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 3'd0,
      OP_PROCESS     = 3'd1,
      OP_PLAY        = 3'd2,
      OP_WRITE       = 3'd3,
      OP_SYNTH_RESET = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STEP  = 2'd0,
      KIND_DECAY = 2'd1,
      KIND_NOTE  = 2'd2,
      KIND_INIT  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHORD_RD,
      ST_CHORD_CHK,
      ST_DELTA_RD,
      ST_DELTA_CHK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/sesu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sesu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sesu_front.sv -----
// Front end: takes request beats, drops unknown operations and queues commands.
// Depends on sesu_pkg.
`default_nettype none

module sesu_front import sesu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [11:0] address, [19:12] data, rest zero
   input  logic [OP_W-1:0]        req_tuser,  // [2:0] operation
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  logic                   cmd_pop
);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              known;
   logic              push;
   cmd_type           entry;

   // Classify the operation code
   always_comb begin
      case (req_tuser)
         OP_TICK, OP_PROCESS, OP_PLAY, OP_WRITE, OP_SYNTH_RESET: known = 1'b1;
         default:                                                known = 1'b0;
      endcase
   end

   assign entry.op   = op_type'(req_tuser);
   assign entry.addr = req_tdata[ADDR_W-1:0];
   assign entry.data = req_tdata[ADDR_W+DATA_W-1:ADDR_W];

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && known;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sesu_back.sv -----
// Back end: executes queued commands against the score memory and counters.
// Depends on sesu_pkg and sesu_ram.
`default_nettype none

module sesu_back import sesu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [NOTE_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0] rsp_tuser,
   output logic              rsp_tlast
);

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [31:0]        sample_ff, sample_in;
   logic [31:0]        net_ff, net_in;
   logic [7:0]         decay_ff, decay_in;
   logic               playing_ff, playing_in;
   logic [CHORD_W-1:0] chord_cnt_ff, chord_cnt_in;
   logic [PTR_W-1:0]   delta_cnt_ff, delta_cnt_in;

   // One result held back until it is known whether it is the last one
   logic               pend_valid_ff, pend_valid_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic [NOTE_W-1:0]  pend_note_ff, pend_note_in;

   // Output register
   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [NOTE_W-1:0]  out_note_ff, out_note_in;
   logic               out_last_ff, out_last_in;

   logic               push;
   logic               push_last;
   logic               out_free;
   logic               ram_we;
   logic               ram_re;
   logic [DATA_W-1:0]  rd_byte;
   logic [31:0]        wr_addr_ext;
   logic               wr_in_range;
   logic               is_stop;
   logic               due;
   logic               chord_stall;
   logic               flush_stall;
   logic               chord_end;
   logic               delta_end;
   logic [PTR_W-1:0]   ptr_inc;

   sesu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SCORE_DEPTH)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr_ext[PTR_W-1:0]),
      .wr_data (cmd.data),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (rd_byte)
   );

   // Shared conditions
   assign wr_addr_ext = 32'(cmd.addr);
   assign wr_in_range = (wr_addr_ext < 32'(SCORE_DEPTH));
   assign out_free    = !out_valid_ff || rsp_tready;
   assign is_stop     = (rd_byte == STOP_BYTE);
   assign due         = ((sample_ff >> TIME_SHIFT) >= net_ff);
   assign chord_stall = pend_valid_ff && !is_stop && !out_free;
   assign flush_stall = pend_valid_ff && !out_free;
   assign chord_end   = rd_byte[NOTE_END_BIT] || (chord_cnt_ff == CHORD_W'(MAX_CHORD - 1));
   assign delta_end   = !is_stop || (delta_cnt_ff == PTR_W'(SCORE_DEPTH - 1));
   assign ptr_inc     = (ptr_ff == PTR_W'(SCORE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_TICK, OP_SYNTH_RESET: state_in = ST_FLUSH;
                  OP_PROCESS:              state_in = (playing_ff && due) ? ST_CHORD_RD
                                                                          : ST_FLUSH;
                  OP_PLAY:                 state_in = ST_DELTA_RD;
                  OP_WRITE:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHORD_RD:  state_in = ST_CHORD_CHK;
         ST_CHORD_CHK: begin
            if (!chord_stall) begin
               state_in = chord_end ? ST_DELTA_RD : ST_CHORD_RD;
            end
         end
         ST_DELTA_RD:  state_in = ST_DELTA_CHK;
         ST_DELTA_CHK: state_in = delta_end ? ST_FLUSH : ST_DELTA_RD;
         ST_FLUSH: begin
            if (!flush_stall) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      ptr_in        = ptr_ff;
      sample_in     = sample_ff;
      net_in        = net_ff;
      decay_in      = decay_ff;
      playing_in    = playing_ff;
      chord_cnt_in  = chord_cnt_ff;
      delta_cnt_in  = delta_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_note_in  = pend_note_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      push          = 1'b0;
      push_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               chord_cnt_in = '0;
               delta_cnt_in = '0;
               unique case (cmd.op)
                  OP_TICK: begin
                     pend_valid_in = 1'b1;
                     pend_kind_in  = KIND_STEP;
                     pend_note_in  = '0;
                     sample_in     = sample_ff + 1'b1;
                     if (decay_ff < DECAY_MAX) begin
                        decay_in = decay_ff + 1'b1;
                     end
                  end
                  OP_PROCESS: begin
                     if (decay_ff >= DECAY_FIRE) begin
                        pend_valid_in = 1'b1;
                        pend_kind_in  = KIND_DECAY;
                        pend_note_in  = '0;
                        decay_in      = '0;
                     end
                  end
                  OP_PLAY: begin
                     sample_in  = '0;
                     net_in     = '0;
                     decay_in   = '0;
                     ptr_in     = '0;
                     playing_in = 1'b1;
                  end
                  OP_WRITE: begin
                     ram_we = wr_in_range;
                  end
                  OP_SYNTH_RESET: begin
                     pend_valid_in = 1'b1;
                     pend_kind_in  = KIND_INIT;
                     pend_note_in  = '0;
                  end
               endcase
            end
         end
         ST_CHORD_RD: begin
            ram_re = 1'b1;
         end
         ST_CHORD_CHK: begin
            if (!chord_stall) begin
               ptr_in       = ptr_inc;
               chord_cnt_in = chord_cnt_ff + 1'b1;
               if (is_stop) begin
                  playing_in = 1'b0;
               end else begin
                  // a new note pushes the held one out as not last
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in  = KIND_NOTE;
                  pend_note_in  = rd_byte;
               end
            end
         end
         ST_DELTA_RD: begin
            ram_re = 1'b1;
         end
         ST_DELTA_CHK: begin
            net_in       = net_ff + 32'(rd_byte);
            ptr_in       = ptr_inc;
            delta_cnt_in = delta_cnt_ff + 1'b1;
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
      endcase
   end

   // Output register load
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_note_in  = out_note_ff;
      out_last_in  = out_last_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_note_in  = pend_note_ff;
         out_last_in  = push_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         sample_ff     <= '0;
         net_ff        <= '0;
         decay_ff      <= '0;
         playing_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         sample_ff     <= sample_in;
         net_ff        <= net_in;
         decay_ff      <= decay_in;
         playing_ff    <= playing_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload and loop counters, no reset
   always_ff @(posedge clock) begin
      chord_cnt_ff <= chord_cnt_in;
      delta_cnt_ff <= delta_cnt_in;
      pend_kind_ff <= pend_kind_in;
      pend_note_ff <= pend_note_in;
      out_kind_ff  <= out_kind_in;
      out_note_ff  <= out_note_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_note_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/score_event_sequencer_unit.sv -----
// Score event sequencer. Request beats carry an operation in req_tuser (tick, process,
// play, write score byte, reset synthesizer); a two-entry command queue separates the
// front end from the executing back end, and results leave through a registered output
// stage. A write or play produces no beat; tick and synthesizer reset produce one beat
// each. In the back end, process and play read score bytes (notes and delta bytes), and
// every byte goes through the single registered read port of the score memory.
// Score memory contents are undefined until written; there is no clearing pass after
// reset.
// Depends on sesu_pkg, sesu_front, sesu_back and sesu_ram.
`default_nettype none

module score_event_sequencer_unit import sesu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [11:0] address, [19:12] data, [23:20] zero
   input  logic [OP_W-1:0]        req_tuser,  // [2:0] operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [NOTE_W-1:0]      rsp_tdata,  // [7:0] note
   output logic [KIND_W-1:0]      rsp_tuser,  // [1:0] kind
   output logic                   rsp_tlast
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   sesu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   sesu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/sesu_checker.sv -----
// Port-level checks on the result stream of the score event sequencer.
// Depends on sesu_pkg and score_event_sequencer_unit_assert.svh; bound to the top level.
`default_nettype none

`include "score_event_sequencer_unit_assert.svh"

module sesu_checker import sesu_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [NOTE_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0] rsp_tuser,
   input logic              rsp_tlast
);

   // A stalled beat stays offered
   `SESU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // Only note beats carry a nonzero byte
   `SESU_ASSERT_IMPLY(a_note_zero, rsp_tvalid && rsp_tuser != KIND_NOTE, rsp_tdata == '0)

   // The stop byte is never played as a note
   `SESU_ASSERT_IMPLY(a_no_stop_note, rsp_tvalid && rsp_tuser == KIND_NOTE, rsp_tdata != STOP_BYTE)

   // Step and init beats are always the only beat of their request
   `SESU_ASSERT_IMPLY(a_single_last, rsp_tvalid && (rsp_tuser == KIND_STEP || rsp_tuser == KIND_INIT), rsp_tlast)

endmodule

bind score_event_sequencer_unit sesu_checker u_checker (.*);

`default_nettype wire
